// ----- rtl/lpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared constants and types for the least recently used page frame
// replacement block.
// ----------------------------------------------------------------------------
package lpfr_pkg;

   localparam int FRAME_COUNT_DEF = 8;
   localparam int PAGE_BITS_DEF   = 16;

   localparam int         FIU_W     = 4;
   localparam logic [3:0] FIU_RESET = 4'd3;

   localparam int FAULT_W = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TOUCH
   } state_type;

endpackage

// ----- rtl/lru_page_frame_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_frame_replacement
// Least recently used page frame replacement. Frame pages and recency ranks
// live in one synchronous memory; a sequencer scans it for a hit or the
// oldest frame, then sweeps it once more to age the ranks.
//
//   channel   ports                       handshake
//   --------  --------------------------  --------------------------------
//   request   start, busy, req_*          taken when start & !busy
//   response  rsp_valid, rsp_*            one-cycle strobe, no back-pressure
//   config    csr_write_en, csr_write_data written when csr_write_en
//
// After a transaction is taken, busy stays high through a lookup scan of up
// to n entries, n being the number of managed frames (a hit in frame k stops
// the scan there), and an update sweep that does a read-modify-write of all
// FRAME_COUNT entries on the single memory port. The response strobe comes in
// the first cycle with busy low and a new request can be taken in that same
// cycle. Reset empties all frames and needs no clearing pass. The response
// side cannot stall.
// ----------------------------------------------------------------------------
module lru_page_frame_replacement #(
   parameter int FRAME_COUNT = lpfr_pkg::FRAME_COUNT_DEF,
   parameter int PAGE_BITS   = lpfr_pkg::PAGE_BITS_DEF,
   localparam int IDX_W      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [PAGE_BITS-1:0]        req_page_number,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [IDX_W-1:0]            rsp_frame_index,
   output logic                        rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]        rsp_evicted_page,
   output logic [lpfr_pkg::FAULT_W-1:0] rsp_fault_total,
   input  logic                        csr_write_en,
   input  logic [lpfr_pkg::FIU_W-1:0]  csr_write_data
);

   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
   localparam int CMP_W  = (CNT_W > lpfr_pkg::FIU_W) ? CNT_W : lpfr_pkg::FIU_W;
   localparam int WORD_W = PAGE_BITS + RANK_W;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAME_COUNT - 1);

   lpfr_pkg::state_type state_ff, state_in;

   logic [lpfr_pkg::FIU_W-1:0]   fiu_ff;
   logic [CNT_W-1:0]             filled_ff, filled_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [CNT_W-1:0]             limit_ff, limit_in;
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic [PAGE_BITS-1:0]         page_ff, page_in;
   logic [IDX_W-1:0]             old_idx_ff, old_idx_in;
   logic [RANK_W-1:0]            old_rank_ff, old_rank_in;
   logic [PAGE_BITS-1:0]         old_page_ff, old_page_in;
   logic                         hit_ff, hit_in;
   logic [IDX_W-1:0]             frame_ff, frame_in;
   logic                         ev_valid_ff, ev_valid_in;
   logic [PAGE_BITS-1:0]         ev_page_ff, ev_page_in;
   logic [lpfr_pkg::FAULT_W-1:0] fault_ff, fault_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [WORD_W-1:0] mem [FRAME_COUNT];
   logic [WORD_W-1:0] mem_rd_ff;
   logic [IDX_W-1:0]  mem_ra;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [WORD_W-1:0] mem_wd;

   logic [CMP_W-1:0]     fiu_ext;
   logic [CNT_W-1:0]     managed;
   logic [PAGE_BITS-1:0] rd_page;
   logic [RANK_W-1:0]    rd_rank;
   logic [RANK_W-1:0]    new_rank;
   logic                 entry_valid;
   logic                 scan_last;
   logic                 touch_last;
   logic                 take_cand;
   logic [IDX_W-1:0]     cand_idx;
   logic [RANK_W-1:0]    cand_rank;
   logic [PAGE_BITS-1:0] cand_page;

   // frame memory: page and rank per entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpfr_pkg::ST_IDLE;
         fiu_ff       <= lpfr_pkg::FIU_RESET;
         filled_ff    <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            fiu_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      limit_ff    <= limit_in;
      cnt_ff      <= cnt_in;
      page_ff     <= page_in;
      old_idx_ff  <= old_idx_in;
      old_rank_ff <= old_rank_in;
      old_page_ff <= old_page_in;
      hit_ff      <= hit_in;
      frame_ff    <= frame_in;
      ev_valid_ff <= ev_valid_in;
      ev_page_ff  <= ev_page_in;
   end

   // managed frame count, clamped to 1..FRAME_COUNT
   always_comb begin
      fiu_ext = CMP_W'(fiu_ff);
      if (fiu_ext == '0) begin
         managed = CNT_W'(1);
      end else if (fiu_ext > CMP_W'(FRAME_COUNT)) begin
         managed = CNT_W'(FRAME_COUNT);
      end else begin
         managed = CNT_W'(fiu_ext);
      end
   end

   assign rd_page     = mem_rd_ff[WORD_W-1:RANK_W];
   assign rd_rank     = mem_rd_ff[RANK_W-1:0];
   assign entry_valid = CNT_W'(cnt_ff) < filled_ff;
   assign scan_last   = (CNT_W'(cnt_ff) + CNT_W'(1)) == n_ff;
   assign touch_last  = cnt_ff == IDX_W'(FRAME_COUNT - 1);
   assign take_cand   = (cnt_ff == '0) || (rd_rank > old_rank_ff);
   assign cand_idx    = take_cand ? cnt_ff  : old_idx_ff;
   assign cand_rank   = take_cand ? rd_rank : old_rank_ff;
   assign cand_page   = take_cand ? rd_page : old_page_ff;

   // aging of one entry during the update sweep
   always_comb begin
      if (cnt_ff == frame_ff) begin
         new_rank = '0;
      end else if (entry_valid && (CNT_W'(rd_rank) < limit_ff) && (rd_rank != RANK_MAX)) begin
         new_rank = rd_rank + RANK_W'(1);
      end else begin
         new_rank = rd_rank;
      end
   end

   always_comb begin
      state_in     = state_ff;
      filled_in    = filled_ff;
      n_in         = n_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      page_in      = page_ff;
      old_idx_in   = old_idx_ff;
      old_rank_in  = old_rank_ff;
      old_page_in  = old_page_ff;
      hit_in       = hit_ff;
      frame_in     = frame_ff;
      ev_valid_in  = ev_valid_ff;
      ev_page_in   = ev_page_ff;
      fault_in     = fault_ff;
      rsp_valid_in = 1'b0;
      mem_ra       = '0;
      mem_we       = 1'b0;
      mem_wa       = cnt_ff;
      mem_wd       = {(cnt_ff == frame_ff) ? page_ff : rd_page, new_rank};

      case (state_ff)
         lpfr_pkg::ST_IDLE: begin
            if (start) begin
               page_in     = req_page_number;
               n_in        = managed;
               cnt_in      = '0;
               hit_in      = 1'b0;
               ev_valid_in = 1'b0;
               ev_page_in  = '0;
               state_in    = lpfr_pkg::ST_SCAN;
            end
         end
         lpfr_pkg::ST_SCAN: begin
            if (entry_valid && (rd_page == page_ff)) begin
               hit_in   = 1'b1;
               frame_in = cnt_ff;
               limit_in = CNT_W'(rd_rank);
               cnt_in   = '0;
               state_in = lpfr_pkg::ST_TOUCH;
            end else if (scan_last) begin
               if (fault_ff != '1) begin
                  fault_in = fault_ff + lpfr_pkg::FAULT_W'(1);
               end
               if (filled_ff < n_ff) begin
                  frame_in  = filled_ff[IDX_W-1:0];
                  filled_in = filled_ff + CNT_W'(1);
                  limit_in  = CNT_W'(FRAME_COUNT);
               end else begin
                  frame_in    = cand_idx;
                  ev_valid_in = 1'b1;
                  ev_page_in  = cand_page;
                  limit_in    = CNT_W'(cand_rank);
               end
               cnt_in   = '0;
               state_in = lpfr_pkg::ST_TOUCH;
            end else begin
               old_idx_in  = cand_idx;
               old_rank_in = cand_rank;
               old_page_in = cand_page;
               cnt_in      = cnt_ff + IDX_W'(1);
               mem_ra      = cnt_ff + IDX_W'(1);
            end
         end
         lpfr_pkg::ST_TOUCH: begin
            mem_we = 1'b1;
            if (touch_last) begin
               rsp_valid_in = 1'b1;
               state_in     = lpfr_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
               mem_ra = cnt_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = lpfr_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy              = state_ff != lpfr_pkg::ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_frame_index   = frame_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;
   assign rsp_fault_total   = fault_ff;

endmodule

// ----- tb/tb_lru_page_frame_replacement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_frame_replacement
// Self-checking testbench for the LRU page frame replacement block. A shadow
// copy of the frame table predicts hit or fault, frame, eviction and fault
// count for every accepted page reference. Directed tests cover fill,
// eviction and the frame-count register limits. Random phases then sweep
// the register while sending references drawn mostly from a small page set.
// ----------------------------------------------------------------------------
module tb_lru_page_frame_replacement;

   localparam int FRAMES    = lpfr_pkg::FRAME_COUNT_DEF;
   localparam int PAGE_W    = lpfr_pkg::PAGE_BITS_DEF;
   localparam int IDX_W     = $clog2(FRAMES);
   localparam int RANK_TOP  = FRAMES - 1;
   localparam int PHASES    = 14;
   localparam int PHASE_LEN = 108;

   typedef struct packed {
      logic                          hit;
      logic [IDX_W-1:0]              frame;
      logic                          ev_valid;
      logic [PAGE_W-1:0]             ev_page;
      logic [lpfr_pkg::FAULT_W-1:0]  faults;
   } page_ref_result_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [PAGE_W-1:0]             req_page_number = '0;
   logic                          rsp_valid;
   logic                          rsp_hit;
   logic [IDX_W-1:0]              rsp_frame_index;
   logic                          rsp_evicted_valid;
   logic [PAGE_W-1:0]             rsp_evicted_page;
   logic [lpfr_pkg::FAULT_W-1:0]  rsp_fault_total;
   logic                          csr_write_en = 1'b0;
   logic [lpfr_pkg::FIU_W-1:0]    csr_write_data = '0;

   // shadow frame table
   logic [PAGE_W-1:0]             shadow_page [FRAMES];
   logic                          shadow_valid [FRAMES];
   int                            shadow_rank [FRAMES];
   int                            shadow_filled;
   logic [lpfr_pkg::FAULT_W-1:0]  shadow_faults;
   logic [lpfr_pkg::FIU_W-1:0]    shadow_frames_in_use;

   page_ref_result_type           pending_results [$];
   page_ref_result_type           oldest_result;
   int                            error_count = 0;
   int                            idle_pct = 0;

   lru_page_frame_replacement DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // age younger valid frames, then make the target most recent
   function automatic void age_frames(input int target, input int limit);
      for (int i = 0; i < FRAMES; i++) begin
         if (i != target && shadow_valid[i] && shadow_rank[i] < limit &&
             shadow_rank[i] < RANK_TOP)
            shadow_rank[i]++;
      end
      shadow_rank[target] = 0;
   endfunction

   function automatic page_ref_result_type predict_reference(input logic [PAGE_W-1:0] page);
      page_ref_result_type r;
      int n;
      int frame;
      int oldest;
      bit found;
      n = int'(shadow_frames_in_use);
      if (n < 1) n = 1;
      if (n > FRAMES) n = FRAMES;
      r = '0;
      found = 1'b0;
      frame = 0;
      for (int i = 0; i < n; i++) begin
         if (!found && shadow_valid[i] && shadow_page[i] == page) begin
            found = 1'b1;
            frame = i;
         end
      end
      if (found) begin
         age_frames(frame, shadow_rank[frame]);
      end else begin
         if (shadow_faults != '1) shadow_faults++;
         if (shadow_filled < n) begin
            frame = shadow_filled;
            shadow_filled++;
            shadow_valid[frame] = 1'b1;
            shadow_page[frame] = page;
            age_frames(frame, RANK_TOP + 1);
         end else begin
            oldest = 0;
            for (int i = 1; i < n; i++) begin
               if (shadow_rank[i] > shadow_rank[oldest]) oldest = i;
            end
            frame = oldest;
            r.ev_valid = 1'b1;
            r.ev_page = shadow_page[frame];
            shadow_page[frame] = page;
            age_frames(frame, shadow_rank[frame]);
         end
      end
      r.hit = found;
      r.frame = frame[IDX_W-1:0];
      r.faults = shadow_faults;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", name, exp_v, act_v,
                     $realtime);
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected transaction at %0t", $realtime);
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("hit", 32'(oldest_result.hit), 32'(rsp_hit));
            check_field("frame_index", 32'(oldest_result.frame), 32'(rsp_frame_index));
            check_field("evicted_valid", 32'(oldest_result.ev_valid),
                        32'(rsp_evicted_valid));
            check_field("evicted_page", 32'(oldest_result.ev_page), 32'(rsp_evicted_page));
            check_field("fault_total", oldest_result.faults, rsp_fault_total);
         end
      end
   end

   task automatic send_reference(input logic [PAGE_W-1:0] page);
      start <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_reference(page));
      if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic drain_block();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_frames_in_use(input logic [lpfr_pkg::FIU_W-1:0] value);
      drain_block();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      shadow_frames_in_use = value;
      csr_write_en <= 1'b0;
   endtask

   // fill three frames, hit, then evict the least recent
   task automatic test_fill_and_evict();
      idle_pct = 30;
      send_reference(16'h0000);
      send_reference(16'hFFFF);
      send_reference(16'hAAAA);
      send_reference(16'h0000);
      send_reference(16'h5555);
      send_reference(16'hFFFF);
      send_reference(16'h5555);
   endtask

   // zero acts as one frame, values above the built count act as the maximum
   task automatic test_register_limits();
      write_frames_in_use(4'd0);
      send_reference(16'h1234);
      send_reference(16'h1234);
      send_reference(16'h8001);
      write_frames_in_use(4'd15);
      send_reference(16'h0001);
      send_reference(16'h8000);
      send_reference(16'h7FFF);
      send_reference(16'hFFFE);
      send_reference(16'h0F0F);
      send_reference(16'h1234);
      send_reference(16'hF0F0);
   endtask

   // lower the frame count while frames are full, then raise it again
   task automatic test_register_shrink_grow();
      write_frames_in_use(4'd2);
      send_reference(16'h4242);
      send_reference(16'h0F0F);
      write_frames_in_use(4'd8);
      send_reference(16'h4242);
      send_reference(16'hC3C3);
   endtask

   // random phases, each with its own frame count and page set
   task automatic test_random_phases();
      logic [lpfr_pkg::FIU_W-1:0] setting_list [PHASES];
      logic [PAGE_W-1:0] page_set [12];
      int set_size;
      setting_list = '{4'd1, 4'd8, 4'd4, 4'd2, 4'd15, 4'd0, 4'd6, 4'd3,
                       4'd8, 4'd5, 4'd7, 4'd1, 4'd8, 4'd4};
      for (int p = 0; p < PHASES; p++) begin
         if (p >= 10 && p < PHASES - 1)
            setting_list[p] = lpfr_pkg::FIU_W'($urandom_range(0, 15));
         write_frames_in_use(setting_list[p]);
         set_size = $urandom_range(2, 12);
         foreach (page_set[k]) page_set[k] = PAGE_W'($urandom_range(0, 65535));
         if (p == PHASES - 1 || $urandom_range(0, 3) == 0) idle_pct = 0;
         else idle_pct = $urandom_range(5, 50);
         for (int k = 0; k < PHASE_LEN; k++) begin
            if ($urandom_range(0, 99) < 75)
               send_reference(page_set[$urandom_range(0, set_size - 1)]);
            else
               send_reference(PAGE_W'($urandom_range(0, 65535)));
         end
      end
   endtask

   initial begin
      foreach (shadow_valid[i]) begin
         shadow_page[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i] = 0;
      end
      shadow_filled = 0;
      shadow_faults = '0;
      shadow_frames_in_use = lpfr_pkg::FIU_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_fill_and_evict();
      test_register_limits();
      test_register_shrink_grow();
      test_random_phases();
      drain_block();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
